// ----- rtl/core/aifp_pkg.sv -----
// Package for the ASCII integer field parser: item, result and state types,
// parse modes, field sizes and per-size limits. No dependencies.
`timescale 1ns / 1ps

package aifp_pkg;

	localparam int CH_W    = 8;
	localparam int SEL_W   = 2;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 4;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_DEC  = 2'd1,
		MODE_HEX  = 2'd2
	} aifp_mode_t;

	typedef enum logic [1:0] {
		SIZE_8  = 2'd0,
		SIZE_16 = 2'd1,
		SIZE_32 = 2'd2
	} aifp_size_t;

	localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
	localparam logic [CH_W-1:0] CH_A_LOW   = 8'h61;
	localparam logic [CH_W-1:0] CH_F_LOW   = 8'h66;
	localparam logic [CH_W-1:0] CH_H_LOW   = 8'h68;
	localparam logic [CH_W-1:0] CH_H_UP    = 8'h48;
	localparam logic [3:0]      HEX_LETTER_ADJ = 4'd9;

	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic             start_req;
		logic [SEL_W-1:0] size_sel;
	} aifp_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               ok;
		logic [COUNT_W-1:0] digit_count;
		logic               is_hex;
	} aifp_result_t;

	typedef struct packed {
		aifp_mode_t         mode;
		aifp_size_t         size;
		logic [COUNT_W-1:0] digits;
		logic [VALUE_W-1:0] acc;
	} aifp_state_t;

	function automatic logic [COUNT_W-1:0] dec_max(input aifp_size_t s);
		case (s)
			SIZE_8:  dec_max = 4'd3;
			SIZE_16: dec_max = 4'd6;
			default: dec_max = 4'd10;
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] hex_max(input aifp_size_t s);
		case (s)
			SIZE_8:  hex_max = 4'd2;
			SIZE_16: hex_max = 4'd4;
			default: hex_max = 4'd8;
		endcase
	endfunction

	function automatic logic [VALUE_W-1:0] width_mask(input aifp_size_t s);
		case (s)
			SIZE_8:  width_mask = 32'h0000_00FF;
			SIZE_16: width_mask = 32'h0000_FFFF;
			default: width_mask = 32'hFFFF_FFFF;
		endcase
	endfunction

endpackage

// ----- rtl/core/aifp_in_if.sv -----
// Character channel: valid/ready with one character beat.
// Depends on aifp_pkg.
`timescale 1ns / 1ps

interface aifp_in_if import aifp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  ch;
	logic             start_req;
	logic [SEL_W-1:0] size_sel;

	modport source (output valid, ch, start_req, size_sel, input ready);
	modport sink   (input valid, ch, start_req, size_sel, output ready);
endinterface

// ----- rtl/core/aifp_out_if.sv -----
// Result channel: valid/ready with one parsed-field beat.
// Depends on aifp_pkg.
`timescale 1ns / 1ps

interface aifp_out_if import aifp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic               ok;
	logic [COUNT_W-1:0] digit_count;
	logic               is_hex;

	modport source (output valid, value, ok, digit_count, is_hex, input ready);
	modport sink   (input valid, value, ok, digit_count, is_hex, output ready);
endinterface

// ----- rtl/core/aifp_step.sv -----
// Next-state and result logic for one character of a numeric field.
// Purely combinational; depends on aifp_pkg.
`timescale 1ns / 1ps

module aifp_step import aifp_pkg::*; (
	input  aifp_item_t   item,
	input  aifp_state_t  cur,
	output aifp_state_t  nxt,
	output logic         res_valid,
	output aifp_result_t res
);

	aifp_state_t        eff;
	logic               is_dec;
	logic               is_letter;
	logic               is_digit;
	logic               full;
	logic [3:0]         nib;
	logic [VALUE_W-1:0] acc_dec;
	logic [VALUE_W-1:0] acc_hex;
	aifp_size_t         sel_size;

	assign is_dec    = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
	assign is_letter = (item.ch >= CH_A_LOW) && (item.ch <= CH_F_LOW);
	assign sel_size  = (item.size_sel == 2'd3) ? SIZE_32 : aifp_size_t'(item.size_sel);

	// acc*10+nib as two shifts and two adds
	assign acc_dec = {eff.acc[VALUE_W-4:0], 3'b000} + {eff.acc[VALUE_W-2:0], 1'b0}
		+ {{(VALUE_W-4){1'b0}}, nib};
	assign acc_hex = {eff.acc[VALUE_W-5:0], nib};

	always_comb begin
		eff = cur;
		if (item.start_req) begin
			eff.size   = sel_size;
			eff.digits = '0;
			eff.acc    = '0;
			eff.mode   = MODE_DEC;
		end
		is_digit = (eff.mode == MODE_HEX) ? (is_dec || is_letter) : is_dec;
		full     = (eff.mode == MODE_HEX) ? (eff.digits >= hex_max(eff.size))
			: (eff.digits >= dec_max(eff.size));
		nib      = (eff.mode == MODE_HEX && is_letter) ? item.ch[3:0] + HEX_LETTER_ADJ
			: item.ch[3:0];
	end

	always_comb begin
		nxt       = eff;
		res_valid = 1'b0;
		res.value       = eff.acc;
		res.ok          = 1'b0;
		res.digit_count = eff.digits;
		res.is_hex      = (eff.mode == MODE_HEX);
		if (item.start_req && (item.ch == CH_H_LOW || item.ch == CH_H_UP)) begin
			nxt.mode = MODE_HEX;
		end else if (eff.mode == MODE_DEC || eff.mode == MODE_HEX) begin
			if (!is_digit || full) begin
				res_valid  = 1'b1;
				res.ok     = is_digit ? 1'b0 : (eff.digits != '0);
				nxt.mode   = MODE_IDLE;
				nxt.digits = '0;
				nxt.acc    = '0;
			end else begin
				nxt.acc    = ((eff.mode == MODE_HEX) ? acc_hex : acc_dec)
					& width_mask(eff.size);
				nxt.digits = eff.digits + 4'd1;
			end
		end else begin
			nxt = cur;
		end
	end

endmodule

// ----- rtl/core/ascii_integer_field_parser_core.sv -----
// ASCII integer field parser: top level with input register, field state
// and result register. Depends on aifp_pkg, aifp_in_if, aifp_out_if, aifp_step.
`timescale 1ns / 1ps

// Usage:
//   item   : one ASCII character per beat. start_req=1 opens a new field and
//            size_sel (0=8, 1=16, 2 or 3=32 bit) fixes its width. A leading
//            'h'/'H' selects hex (lower-case digits), else decimal.
//   result : one beat per finished field: value, ok, digit_count, is_hex.
//            The character that ends a field is consumed by it; characters
//            outside a field are dropped with no result.
// Path: an accepted character is captured in the input register, then parsed
//   into the field state; its result beat, if any, goes to the result register.
// Throughput: one character per cycle while no result waits on result.ready. The
//   field state is updated through the accumulate path (acc*10+d or acc<<4|d).
// Reset: arst_n clears the input and result valid flags and returns the
//   parser to idle with an empty accumulator.
// Stall: while a result waits on result.ready, the character in the input
//   register is held; item.ready stays high until that register is full.
module ascii_integer_field_parser_core import aifp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	aifp_in_if.sink           item,
	aifp_out_if.source        result
);

	// input stage
	logic         valid_s1;
	aifp_item_t   item_s1;

	// field state and result register
	aifp_state_t  st_q;
	aifp_state_t  st_nxt;
	logic         out_valid_q;
	aifp_result_t out_q;

	logic         step_valid;
	aifp_result_t step_res;
	logic         adv;

	// the stage-1 character is parsed when the result slot is free or draining
	assign adv        = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.ch        <= item.ch;
			item_s1.start_req <= item.start_req;
			item_s1.size_sel  <= item.size_sel;
		end
	end

	aifp_step u_step (
		.item      (item_s1),
		.cur       (st_q),
		.nxt       (st_nxt),
		.res_valid (step_valid),
		.res       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode   <= MODE_IDLE;
			st_q.size   <= SIZE_8;
			st_q.digits <= '0;
			st_q.acc    <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			out_valid_q <= adv && step_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && step_valid) begin
			out_q <= step_res;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.value       = out_q.value;
	assign result.ok          = out_q.ok;
	assign result.digit_count = out_q.digit_count;
	assign result.is_hex      = out_q.is_hex;

`ifndef SYNTHESIS
	// a field that emitted a result leaves the parser idle and empty
	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && step_valid |=> st_q.mode == MODE_IDLE && st_q.acc == '0)
		else $error("parser not idle after result");

	// digit count never passes the 32-bit decimal limit
	a_digits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.digits <= 4'd10)
		else $error("digit count out of range");

	// an 8-bit field keeps its accumulator within 8 bits
	a_acc_width: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.size == SIZE_8 |-> st_q.acc[VALUE_W-1:8] == '0)
		else $error("accumulator exceeds field width");

	// a good field always carries at least one digit
	a_ok_digits: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ok |-> result.digit_count != '0)
		else $error("ok result with no digits");
`endif

endmodule
